[sv/vtg_pkg.sv]
// ----------------------------------------------------------------------------
// vtg_pkg
// Shared types and constants of the vector tile geometry decoder.
// ----------------------------------------------------------------------------
package vtg_pkg;

  // Default widths of the cursor arithmetic and of the ring point counter.
  localparam int unsigned COORD_BITS_DEF  = 32;
  localparam int unsigned COUNT_BITS_DEF  = 24;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  // A varint holds at most five bytes of seven payload bits each.
  localparam int unsigned VARINT_BITS      = 35;
  localparam int unsigned VARINT_MAX_BYTES = 5;

  // Command word: id in the low bits, repeat count above it.
  localparam int unsigned CMD_ID_BITS = 3;
  localparam int unsigned REPEAT_BITS = 32 - CMD_ID_BITS;

  localparam logic [CMD_ID_BITS-1:0] CMD_MOVE  = 3'd1;
  localparam logic [CMD_ID_BITS-1:0] CMD_LINE  = 3'd2;
  localparam logic [CMD_ID_BITS-1:0] CMD_CLOSE = 3'd7;

  // Result field widths on the output stream.
  localparam int unsigned OUT_COORD_BITS = 32;
  localparam int unsigned OUT_COUNT_BITS = 24;

  // Configuration port.
  localparam int unsigned EXTENT_BITS         = 17;
  localparam logic [EXTENT_BITS-1:0] EXTENT_RESET = 17'd4096;
  localparam int unsigned PADDR_BITS          = 3;
  localparam logic        REG_TILE_EXTENT     = 1'b0;

  // Work requests passed from the front end to the back end.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_MOVE,
    OP_LINE,
    OP_CLOSE,
    OP_ERROR
  } op_e;

  typedef struct packed {
    op_e  op;
    logic last;
  } entry_ctrl_t;

  typedef enum logic [1:0] {
    KIND_POINT    = 2'd0,
    KIND_RING_END = 2'd1,
    KIND_ERROR    = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    PH_START,
    PH_SECOND,
    PH_END
  } phase_e;

  typedef struct packed {
    kind_e                     kind;
    logic [OUT_COUNT_BITS-1:0] count;
    logic [OUT_COORD_BITS-1:0] y;
    logic [OUT_COORD_BITS-1:0] x;
    logic                      last;
  } result_t;

endpackage

[sv/vtg_front.sv]
// ----------------------------------------------------------------------------
// vtg_front
// Byte intake: assembles varints, tracks the active command and turns each
// byte into at most one work request for the back end.
// ----------------------------------------------------------------------------
module vtg_front #(
  parameter int unsigned COORD_BITS = vtg_pkg::COORD_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [7:0]            in_byte_i,
  input  logic                  in_last_i,
  input  logic                  space_i,
  output logic                  push_o,
  output vtg_pkg::entry_ctrl_t  push_ctrl_o,
  output logic [COORD_BITS-1:0] push_dx_o,
  output logic [COORD_BITS-1:0] push_dy_o
);
  import vtg_pkg::*;

  logic [VARINT_BITS-1:0] accum_q, accum_d;
  logic [2:0]             nbytes_q, nbytes_d;
  logic [CMD_ID_BITS-1:0] cmd_q, cmd_d;
  logic [REPEAT_BITS-1:0] repeats_q, repeats_d;
  logic                   expect_y_q, expect_y_d;
  logic [COORD_BITS-1:0]  dx_q, dx_d;

  logic                   accept;
  logic [5:0]             shamt;
  logic [VARINT_BITS-1:0] chunk;
  logic [VARINT_BITS-1:0] value;
  logic [63:0]            mag;
  logic [63:0]            zz_wide;
  logic [COORD_BITS-1:0]  zz;
  logic [REPEAT_BITS-1:0] word_cnt;
  logic [CMD_ID_BITS-1:0] word_id;
  op_e                    op;

  assign accept     = in_valid_i & space_i;
  assign in_ready_o = space_i;

  assign shamt    = 6'(nbytes_q) * 6'd7;
  assign chunk    = VARINT_BITS'(in_byte_i[6:0]) << shamt;
  assign value    = accum_q | chunk;
  // Zigzag: an odd code is the complement of half its value.
  assign mag      = 64'(value[VARINT_BITS-1:1]);
  assign zz_wide  = value[0] ? ~mag : mag;
  assign zz       = zz_wide[COORD_BITS-1:0];
  assign word_id  = value[CMD_ID_BITS-1:0];
  assign word_cnt = value[31:CMD_ID_BITS];

  always_comb begin
    accum_d    = accum_q;
    nbytes_d   = nbytes_q;
    cmd_d      = cmd_q;
    repeats_d  = repeats_q;
    expect_y_d = expect_y_q;
    dx_d       = dx_q;
    op         = OP_NONE;
    if (accept) begin
      if (!in_byte_i[7]) begin
        accum_d  = '0;
        nbytes_d = '0;
        if (repeats_q == '0) begin
          cmd_d      = word_id;
          expect_y_d = 1'b0;
          if (word_cnt != '0) begin
            if (word_id == CMD_MOVE || word_id == CMD_LINE) begin
              repeats_d = word_cnt;
            end else if (word_id == CMD_CLOSE) begin
              op = OP_CLOSE;
            end
          end
        end else if (!expect_y_q) begin
          dx_d       = zz;
          expect_y_d = 1'b1;
        end else begin
          expect_y_d = 1'b0;
          repeats_d  = repeats_q - 1'b1;
          op         = (cmd_q == CMD_MOVE) ? OP_MOVE : OP_LINE;
        end
      end else if (nbytes_q == 3'(VARINT_MAX_BYTES - 1)) begin
        // Continuation bit still set on the fifth byte.
        accum_d    = '0;
        nbytes_d   = '0;
        repeats_d  = '0;
        expect_y_d = 1'b0;
        op         = OP_ERROR;
      end else begin
        accum_d  = value;
        nbytes_d = nbytes_q + 3'd1;
      end
      if (in_last_i) begin
        if (nbytes_d != '0) begin
          op = OP_ERROR;
        end
        accum_d    = '0;
        nbytes_d   = '0;
        cmd_d      = '0;
        repeats_d  = '0;
        expect_y_d = 1'b0;
        dx_d       = '0;
      end
    end
  end

  assign push_o           = accept & ((op != OP_NONE) | in_last_i);
  assign push_ctrl_o.op   = op;
  assign push_ctrl_o.last = in_last_i;
  assign push_dx_o        = dx_q;
  assign push_dy_o        = zz;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accum_q    <= '0;
      nbytes_q   <= '0;
      cmd_q      <= '0;
      repeats_q  <= '0;
      expect_y_q <= 1'b0;
      dx_q       <= '0;
    end else begin
      accum_q    <= accum_d;
      nbytes_q   <= nbytes_d;
      cmd_q      <= cmd_d;
      repeats_q  <= repeats_d;
      expect_y_q <= expect_y_d;
      dx_q       <= dx_d;
    end
  end

endmodule

[sv/vtg_queue.sv]
// ----------------------------------------------------------------------------
// vtg_queue
// Short register queue that decouples the byte intake from the back end.
// ----------------------------------------------------------------------------
module vtg_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = vtg_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             space_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] rdata_o
);
  import vtg_pkg::*;

  localparam int unsigned PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    mem_q [DEPTH];
  logic [PTR_BITS-1:0] wptr_q, rptr_q;
  logic [CNT_BITS-1:0] count_q;
  logic                do_push, do_pop;

  assign space_o = (count_q != CNT_BITS'(DEPTH));
  assign valid_o = (count_q != '0);
  assign rdata_o = mem_q[rptr_q];
  assign do_push = push_i & space_o;
  assign do_pop  = pop_i & valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

[sv/vtg_back.sv]
// ----------------------------------------------------------------------------
// vtg_back
// Cursor and ring engine: carries out the queued work requests and delivers
// at most one result per cycle into the output register, while it is empty or read.
// ----------------------------------------------------------------------------
module vtg_back #(
  parameter int unsigned COORD_BITS = vtg_pkg::COORD_BITS_DEF,
  parameter int unsigned COUNT_BITS = vtg_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          head_valid_i,
  input  vtg_pkg::entry_ctrl_t          head_ctrl_i,
  input  logic [COORD_BITS-1:0]         head_dx_i,
  input  logic [COORD_BITS-1:0]         head_dy_i,
  input  logic [vtg_pkg::EXTENT_BITS-1:0] extent_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output vtg_pkg::result_t              out_result_o
);
  import vtg_pkg::*;

  phase_e                phase_q, phase_d;
  logic [COORD_BITS-1:0] cursor_x_q, cursor_x_d, cursor_y_q, cursor_y_d;
  logic [COORD_BITS-1:0] first_x_q, first_x_d, first_y_q, first_y_d;
  logic [COORD_BITS-1:0] prev_x_q, prev_x_d, prev_y_q, prev_y_d;
  logic [COUNT_BITS-1:0] ring_q, ring_d;
  logic                  out_valid_q, out_valid_d;
  result_t               res_q, res_d;

  logic                  step, emit, clr, dup, last;
  logic [COORD_BITS-1:0] ext_c, flip_first, flip_cur;
  logic [COUNT_BITS-1:0] ring_inc;

  function automatic logic [OUT_COORD_BITS-1:0] coord_out(input logic [COORD_BITS-1:0] c);
    logic [63:0] w;
    w = 64'(c);
    return w[OUT_COORD_BITS-1:0];
  endfunction

  function automatic logic [OUT_COUNT_BITS-1:0] count_out(input logic [COUNT_BITS-1:0] c);
    logic [31:0] w;
    w = 32'(c);
    return w[OUT_COUNT_BITS-1:0];
  endfunction

  assign step       = head_valid_i & (~out_valid_q | out_ready_i);
  assign last       = head_ctrl_i.last;
  assign ext_c      = COORD_BITS'(64'(extent_i));
  assign flip_first = ext_c - first_y_q;
  assign flip_cur   = ext_c - cursor_y_q;
  assign ring_inc   = (ring_q == '1) ? ring_q : ring_q + 1'b1;
  assign dup        = (ring_q != '0) && (cursor_x_q == prev_x_q) && (cursor_y_q == prev_y_q);

  always_comb begin
    phase_d    = phase_q;
    cursor_x_d = cursor_x_q;
    cursor_y_d = cursor_y_q;
    first_x_d  = first_x_q;
    first_y_d  = first_y_q;
    prev_x_d   = prev_x_q;
    prev_y_d   = prev_y_q;
    ring_d     = ring_q;
    res_d      = res_q;
    emit       = 1'b0;
    clr        = 1'b0;
    pop_o      = 1'b0;
    if (step) begin
      unique case (phase_q)
        PH_START: begin
          case (head_ctrl_i.op) inside
            OP_MOVE, OP_LINE: begin
              cursor_x_d = cursor_x_q + head_dx_i;
              cursor_y_d = cursor_y_q + head_dy_i;
              // moveTo closes the open ring; its point always follows.
              if (head_ctrl_i.op == OP_MOVE && ring_q != '0) begin
                emit   = 1'b1;
                res_d  = '{KIND_RING_END, count_out(ring_q), '0, '0, 1'b0};
                ring_d = '0;
              end
              phase_d = PH_SECOND;
            end
            OP_CLOSE: begin
              if (ring_q != '0) begin
                emit    = 1'b1;
                res_d   = '{KIND_POINT, '0, coord_out(flip_first), coord_out(first_x_q), 1'b0};
                phase_d = PH_SECOND;
              end else begin
                pop_o = 1'b1;
                clr   = last;
              end
            end
            OP_ERROR: begin
              emit  = 1'b1;
              res_d = '{KIND_ERROR, '0, '0, '0, !(last && ring_q != '0)};
              if (last && ring_q != '0) begin
                phase_d = PH_END;
              end else begin
                pop_o = 1'b1;
                clr   = last;
              end
            end
            default: begin
              // Bare field end.
              if (last && ring_q != '0) begin
                emit  = 1'b1;
                res_d = '{KIND_RING_END, count_out(ring_q), '0, '0, 1'b1};
              end
              pop_o = 1'b1;
              clr   = last;
            end
          endcase
        end
        PH_SECOND: begin
          case (head_ctrl_i.op) inside
            OP_MOVE, OP_LINE: begin
              if (!dup) begin
                emit  = 1'b1;
                res_d = '{KIND_POINT, '0, coord_out(flip_cur), coord_out(cursor_x_q), !last};
                if (ring_q == '0) begin
                  first_x_d = cursor_x_q;
                  first_y_d = cursor_y_q;
                end
                prev_x_d = cursor_x_q;
                prev_y_d = cursor_y_q;
                ring_d   = ring_inc;
                if (last) begin
                  phase_d = PH_END;
                end else begin
                  pop_o   = 1'b1;
                  phase_d = PH_START;
                end
              end else begin
                // A repeated point is dropped; the ring stays open unless the field ends here.
                if (last) begin
                  emit  = 1'b1;
                  res_d = '{KIND_RING_END, count_out(ring_q), '0, '0, 1'b1};
                  clr   = 1'b1;
                end
                pop_o   = 1'b1;
                phase_d = PH_START;
              end
            end
            default: begin
              emit    = 1'b1;
              res_d   = '{KIND_RING_END, count_out(ring_inc), '0, '0, 1'b1};
              ring_d  = '0;
              pop_o   = 1'b1;
              clr     = last;
              phase_d = PH_START;
            end
          endcase
        end
        PH_END: begin
          emit    = 1'b1;
          res_d   = '{KIND_RING_END, count_out(ring_q), '0, '0, 1'b1};
          clr     = 1'b1;
          pop_o   = 1'b1;
          phase_d = PH_START;
        end
        default: begin
          phase_d = PH_START;
        end
      endcase
    end
    if (clr) begin
      cursor_x_d = '0;
      cursor_y_d = '0;
      first_x_d  = '0;
      first_y_d  = '0;
      prev_x_d   = '0;
      prev_y_d   = '0;
      ring_d     = '0;
    end
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_START;
      cursor_x_q  <= '0;
      cursor_y_q  <= '0;
      first_x_q   <= '0;
      first_y_q   <= '0;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      ring_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      cursor_x_q  <= cursor_x_d;
      cursor_y_q  <= cursor_y_d;
      first_x_q   <= first_x_d;
      first_y_q   <= first_y_d;
      prev_x_q    <= prev_x_d;
      prev_y_q    <= prev_y_d;
      ring_q      <= ring_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_valid_o  = out_valid_q;
  assign out_result_o = res_q;

endmodule

[sv/vector_tile_geometry_decoder.sv]
// ----------------------------------------------------------------------------
// vector_tile_geometry_decoder
// Decodes the command stream of one vector tile geometry field into points,
// ring ends and malformed varint reports.
// ----------------------------------------------------------------------------
// The block takes one geometry byte per cycle for as long as its request
// queue (QUEUE_DEPTH entries) has room; every byte that completes a closePath
// command or a coordinate pair, ends the field or breaks a varint places one
// request in the queue. The back end handles a coordinate pair in two steps
// (cursor add, then duplicate test and y flip), and one result leaves the
// output register per cycle while the sink is ready. A point needs at least
// two bytes, so a run of pairs streams at one byte per cycle while the sink
// takes every result.
// Results of one byte arrive in order with tlast on the final one.
module vector_tile_geometry_decoder #(
  parameter int unsigned COORD_BITS  = vtg_pkg::COORD_BITS_DEF,
  parameter int unsigned COUNT_BITS  = vtg_pkg::COUNT_BITS_DEF,
  parameter int unsigned QUEUE_DEPTH = vtg_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Byte stream.
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [7:0]                     s_axis_tdata_i,   // [7:0] geom_byte
  input  logic                           s_axis_tlast_i,   // last_byte
  // Result stream.
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // [31:0] point_x, [63:32] point_y, [87:64] ring_points
  output logic [87:0]                    m_axis_tdata_o,
  output logic [1:0]                     m_axis_tuser_o,   // [1:0] result_kind
  output logic                           m_axis_tlast_o,   // last_result
  // Configuration.
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [vtg_pkg::PADDR_BITS-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import vtg_pkg::*;

  localparam int unsigned CTRL_BITS  = $bits(entry_ctrl_t);
  localparam int unsigned ENTRY_BITS = CTRL_BITS + 2 * COORD_BITS;

  logic [EXTENT_BITS-1:0] extent_q;

  logic                  push, space, pop, head_valid;
  entry_ctrl_t           push_ctrl, head_ctrl;
  logic [COORD_BITS-1:0] push_dx, push_dy, head_dx, head_dy;
  logic [ENTRY_BITS-1:0] wdata, rdata;
  result_t               result;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TILE_EXTENT) ? 32'(extent_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      extent_q <= EXTENT_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_TILE_EXTENT) begin
      extent_q <= pwdata[EXTENT_BITS-1:0];
    end
  end

  vtg_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_byte_i  (s_axis_tdata_i),
    .in_last_i  (s_axis_tlast_i),
    .space_i    (space),
    .push_o     (push),
    .push_ctrl_o(push_ctrl),
    .push_dx_o  (push_dx),
    .push_dy_o  (push_dy)
  );

  assign wdata = {push_ctrl, push_dx, push_dy};

  vtg_queue #(
    .WIDTH(ENTRY_BITS),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i(wdata),
    .space_o(space),
    .pop_i  (pop),
    .valid_o(head_valid),
    .rdata_o(rdata)
  );

  assign head_ctrl = entry_ctrl_t'(rdata[ENTRY_BITS-1 -: CTRL_BITS]);
  assign head_dx   = rdata[2*COORD_BITS-1:COORD_BITS];
  assign head_dy   = rdata[COORD_BITS-1:0];

  vtg_back #(
    .COORD_BITS(COORD_BITS),
    .COUNT_BITS(COUNT_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(head_valid),
    .head_ctrl_i (head_ctrl),
    .head_dx_i   (head_dx),
    .head_dy_i   (head_dy),
    .extent_i    (extent_q),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_result_o(result)
  );

  assign m_axis_tdata_o = {result.count, result.y, result.x};
  assign m_axis_tuser_o = result.kind;
  assign m_axis_tlast_o = result.last;

endmodule

[sv/vtg_checker.sv]
// ----------------------------------------------------------------------------
// vtg_checker
// Port level checks of the geometry decoder's result stream.
// ----------------------------------------------------------------------------
module vtg_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [87:0] m_axis_tdata_o,
  input logic [1:0]  m_axis_tuser_o,
  input logic        m_axis_tlast_o
);
  import vtg_pkg::*;

  // A stalled result holds its contents.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o)
      && $stable(m_axis_tuser_o) && $stable(m_axis_tlast_o))
    else $error("result changed while stalled");

  // Error reports carry no coordinates and no count.
  a_error_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == KIND_ERROR |-> m_axis_tdata_o == '0)
    else $error("error result with data");

  // Ring ends carry no coordinates.
  a_ring_end_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == KIND_RING_END |-> m_axis_tdata_o[63:0] == '0)
    else $error("ring end with coordinates");

  // Points carry no ring count.
  a_point_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == KIND_POINT |-> m_axis_tdata_o[87:64] == '0)
    else $error("point with ring count");

endmodule

bind vector_tile_geometry_decoder vtg_checker u_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o),
  .m_axis_tuser_o (m_axis_tuser_o),
  .m_axis_tlast_o (m_axis_tlast_o)
);

[verif/vector_tile_geometry_decoder_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vector_tile_geometry_decoder_test
// Self-checking bench for the geometry command decoder. Byte requests are
// streamed in with random gaps and results are drained with random stalls.
// Every accepted byte is decoded by a behavioural copy of the block, and
// each result is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module vector_tile_geometry_decoder_test;
  import vtg_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned PHASE_BYTES   = 42;
  localparam int unsigned PHASE_COUNT   = 6;
  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned PRINT_LIMIT   = 200;
  localparam logic [23:0] RING_MAX      = '1;

  localparam logic [PADDR_BITS-1:0] ADDR_TILE_EXTENT = PADDR_BITS'(4 * REG_TILE_EXTENT);

  // Command ids that the decoder does not act on.
  localparam logic [CMD_ID_BITS-1:0] CMD_VOID     = 3'd0;
  localparam logic [CMD_ID_BITS-1:0] CMD_SPARE_LO = 3'd3;
  localparam logic [CMD_ID_BITS-1:0] CMD_SPARE_HI = 3'd6;

  typedef struct {
    kind_e       kind;
    logic [31:0] x;
    logic [31:0] y;
    logic [23:0] points;
    logic        last;
  } geom_result_t;

  class geometry_decode_check;
    logic [16:0]  extent;
    logic [63:0]  acc;
    int unsigned  acc_bytes;
    logic [2:0]   cmd;
    logic [28:0]  repeats;
    bit           want_y;
    logic [31:0]  held_dx, cur_x, cur_y, start_x, start_y, last_x, last_y;
    logic [23:0]  ring_len;
    geom_result_t awaited_results[$];
    geom_result_t step_out[$];
    int unsigned  mismatches;
    int unsigned  printed;

    function new();
      extent     = EXTENT_RESET;
      mismatches = 0;
      printed    = 0;
      clear_field();
    endfunction

    function void clear_field();
      acc       = '0;
      acc_bytes = 0;
      cmd       = '0;
      repeats   = '0;
      want_y    = 1'b0;
      held_dx   = '0;
      cur_x     = '0;
      cur_y     = '0;
      start_x   = '0;
      start_y   = '0;
      last_x    = '0;
      last_y    = '0;
      ring_len  = '0;
    endfunction

    function logic [31:0] unzigzag(logic [63:0] v);
      return v[0] ? ~v[32:1] : v[32:1];
    endfunction

    function logic [31:0] flipped(logic [31:0] y);
      return {15'd0, extent} - y;
    endfunction

    function void emit(kind_e k, logic [31:0] x, logic [31:0] y, logic [23:0] n);
      geom_result_t r;
      r.kind   = k;
      r.x      = x;
      r.y      = y;
      r.points = n;
      r.last   = 1'b0;
      step_out = {step_out, r};
    endfunction

    function void close_ring(logic [23:0] n);
      emit(KIND_RING_END, '0, '0, n);
      ring_len = '0;
    endfunction

    function void on_varint(logic [63:0] v);
      logic [31:0] word;
      logic [23:0] n;
      if (repeats == '0) begin
        word   = v[31:0];
        cmd    = word[2:0];
        want_y = 1'b0;
        if (word[31:3] == '0) return;
        if (cmd == CMD_MOVE || cmd == CMD_LINE) begin
          repeats = word[31:3];
        end else if (cmd == CMD_CLOSE && ring_len != '0) begin
          n = (ring_len < RING_MAX) ? ring_len + 24'd1 : ring_len;
          emit(KIND_POINT, start_x, flipped(start_y), '0);
          close_ring(n);
        end
        return;
      end
      if (!want_y) begin
        held_dx = unzigzag(v);
        want_y  = 1'b1;
        return;
      end
      want_y  = 1'b0;
      repeats = repeats - 29'd1;
      if (cmd == CMD_MOVE && ring_len != '0) close_ring(ring_len);
      cur_x = cur_x + held_dx;
      cur_y = cur_y + unzigzag(v);
      // A pair that lands on the previous point of the ring is dropped.
      if (ring_len == '0 || cur_x != last_x || cur_y != last_y) begin
        if (ring_len == '0) begin
          start_x = cur_x;
          start_y = cur_y;
        end
        last_x = cur_x;
        last_y = cur_y;
        if (ring_len < RING_MAX) ring_len = ring_len + 24'd1;
        emit(KIND_POINT, cur_x, flipped(cur_y), '0);
      end
    endfunction

    function void decode_byte(logic [7:0] b, bit fin);
      logic [63:0]  v;
      geom_result_t r;
      step_out.delete();
      acc       = acc | (64'(b[6:0]) << (7 * acc_bytes));
      acc_bytes = acc_bytes + 1;
      if (!b[7]) begin
        v         = acc;
        acc       = '0;
        acc_bytes = 0;
        on_varint(v);
      end else if (acc_bytes >= VARINT_MAX_BYTES) begin
        // Over-long varint: the active command goes, cursor and ring stay.
        acc       = '0;
        acc_bytes = 0;
        repeats   = '0;
        want_y    = 1'b0;
        emit(KIND_ERROR, '0, '0, '0);
      end
      if (fin) begin
        if (acc_bytes > 0) emit(KIND_ERROR, '0, '0, '0);
        if (ring_len != '0) close_ring(ring_len);
        clear_field();
      end
      foreach (step_out[i]) begin
        r               = step_out[i];
        r.last          = (i == step_out.size() - 1);
        awaited_results = {awaited_results, r};
      end
    endfunction

    function void report(string field, logic [31:0] want, logic [31:0] got);
      mismatches++;
      if (printed < PRINT_LIMIT) begin
        printed++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      end
    endfunction

    function void match_result(geom_result_t got);
      geom_result_t want;
      if (awaited_results.size() == 0) begin
        mismatches++;
        if (printed < PRINT_LIMIT) begin
          printed++;
          $display("%0t: result with none expected, actual kind %0d x %h y %h points %h",
                   $time, got.kind, got.x, got.y, got.points);
        end
        return;
      end
      want = awaited_results.pop_front();
      if (got.kind !== want.kind) report("result_kind", 32'(want.kind), 32'(got.kind));
      if (got.x !== want.x) report("point_x", want.x, got.x);
      if (got.y !== want.y) report("point_y", want.y, got.y);
      if (got.points !== want.points) report("ring_points", 32'(want.points), 32'(got.points));
      if (got.last !== want.last) report("last_result", 32'(want.last), 32'(got.last));
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i;   // [7:0] geom_byte
  logic        s_axis_tlast_i;   // last_byte
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [87:0] m_axis_tdata_o;   // [31:0] point_x, [63:32] point_y, [87:64] ring_points
  logic [1:0]  m_axis_tuser_o;   // [1:0] result_kind
  logic        m_axis_tlast_o;   // last_result
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [PADDR_BITS-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  geometry_decode_check board = new();
  logic [7:0]  field_bytes[$];
  int          src_gap_max    = 0;
  int          sink_stall_max = 0;
  int unsigned cycle_count    = 0;

  vector_tile_geometry_decoder u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Field encoding helpers.
  function automatic void append_byte(logic [7:0] b);
    field_bytes = {field_bytes, b};
  endfunction

  function automatic logic [63:0] zz(int d);
    return 64'(32'((d <<< 1) ^ (d >>> 31)));
  endfunction

  function automatic logic [63:0] command(logic [2:0] id, logic [28:0] n);
    return {32'd0, n, id};
  endfunction

  function automatic void add_varint(logic [63:0] v);
    logic [7:0] b;
    do begin
      b = {1'b0, v[6:0]};
      v = v >> 7;
      if (v != '0) b[7] = 1'b1;
      append_byte(b);
    end while (v != '0);
  endfunction

  function automatic logic [63:0] random_param();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return zz(int'($urandom_range(0, 6)) - 3);
    if (roll < 80) return zz(int'($urandom_range(0, 65535)) - 32768);
    if (roll < 95) return 64'($urandom);
    // Varint of up to five bytes, top bits beyond the coordinate width included.
    return {29'd0, 3'($urandom_range(0, 7)), 32'($urandom)};
  endfunction

  function automatic void add_pair(bit allow_dup);
    if (allow_dup && $urandom_range(0, 6) == 0) begin
      add_varint(zz(0));
      add_varint(zz(0));
    end else begin
      add_varint(random_param());
      add_varint(random_param());
    end
  endfunction

  function automatic void build_field();
    int         roll;
    int         reps;
    logic [2:0] id;
    field_bytes.delete();
    if ($urandom_range(0, 99) < 55) begin
      // Well-formed polygon rings with random coordinates.
      repeat ($urandom_range(1, 2)) begin
        add_varint(command(CMD_MOVE, 29'd1));
        add_pair(1'b0);
        reps = $urandom_range(1, 4);
        add_varint(command(CMD_LINE, 29'(reps)));
        repeat (reps) add_pair(1'b1);
        roll = $urandom_range(0, 99);
        if (roll < 20) add_varint(command(CMD_CLOSE, 29'd2));
        else if (roll < 85) add_varint(command(CMD_CLOSE, 29'd1));
      end
    end else begin
      repeat ($urandom_range(1, 4)) begin
        roll = $urandom_range(0, 99);
        if (roll < 30) begin
          reps = $urandom_range(1, 2);
          add_varint(command(CMD_MOVE, 29'(reps)));
          repeat (reps) add_pair(1'b0);
        end else if (roll < 60) begin
          reps = $urandom_range(1, 4);
          add_varint(command(CMD_LINE, 29'(reps)));
          repeat (reps) add_pair(1'b1);
        end else if (roll < 72) begin
          add_varint(command(CMD_CLOSE, 29'($urandom_range(1, 2))));
        end else if (roll < 80) begin
          id = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
          if ($urandom_range(0, 4) == 0) id = CMD_VOID;
          add_varint(command(id, 29'($urandom_range(1, 3))));
        end else if (roll < 86) begin
          add_varint(command(3'($urandom), '0));
        end else if (roll < 92) begin
          add_varint(64'($urandom));
        end else begin
          repeat ($urandom_range(1, 5)) append_byte(8'($urandom_range(0, 255)));
        end
      end
    end
    roll = $urandom_range(0, 99);
    if (roll < 6) begin
      repeat (VARINT_MAX_BYTES) append_byte(8'h80 | 8'($urandom_range(0, 127)));
    end else if (roll < 12 && field_bytes.size() > 2) begin
      repeat ($urandom_range(1, 2)) void'(field_bytes.pop_back());
    end else if (roll < 17) begin
      // The field ends part way through a varint.
      append_byte(8'h80 | 8'($urandom_range(0, 127)));
    end
    if (field_bytes.size() == 0) add_varint(command(CMD_VOID, '0));
  endfunction

  // All driving tasks are entered and left just after a falling edge.
  task automatic send_byte(logic [7:0] b, bit fin);
    int gap;
    gap = $urandom_range(0, src_gap_max);
    if (gap > 0) begin
      s_axis_tvalid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i  = b;
    s_axis_tlast_i  = fin;
    do @(posedge clk_i); while (!s_axis_tready_o);
    board.decode_byte(b, fin);
    @(negedge clk_i);
  endtask

  task automatic drain(int hold);
    s_axis_tvalid_i = 1'b0;
    do @(negedge clk_i); while (board.awaited_results.size() != 0);
    repeat (hold) @(negedge clk_i);
  endtask

  task automatic send_field(int pause_at);
    for (int i = 0; i < field_bytes.size(); i++) begin
      if (i == pause_at) drain(0);
      send_byte(field_bytes[i], i == field_bytes.size() - 1);
    end
  endtask

  task automatic program_extent(logic [31:0] value);
    logic [31:0] readback;
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = ADDR_TILE_EXTENT;
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    board.extent = value[16:0];
    @(negedge clk_i);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    readback = prdata;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    if (readback !== {15'd0, value[16:0]}) board.report("tile_extent", {15'd0, value[16:0]},
                                                        readback);
  endtask

  // Result side: random stall before each result request.
  initial begin
    geom_result_t got;
    int           stall;
    m_axis_tready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = $urandom_range(0, sink_stall_max);
      if (stall > 0) begin
        m_axis_tready_i = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready_i = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      got.kind   = kind_e'(m_axis_tuser_o);
      got.x      = m_axis_tdata_o[31:0];
      got.y      = m_axis_tdata_o[63:32];
      got.points = m_axis_tdata_o[87:64];
      got.last   = m_axis_tlast_o;
      board.match_result(got);
      @(negedge clk_i);
    end
  end

  initial begin
    int          phase_bytes;
    int          pause_at;
    bit          opening;
    logic [31:0] extent_plan[PHASE_COUNT];
    int          src_plan[PHASE_COUNT];
    int          sink_plan[PHASE_COUNT];

    extent_plan = '{32'd1, 32'd65536, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'd4096};
    src_plan    = '{10, 0, 10, 0, 3, 10};
    sink_plan   = '{10, 10, 0, 0, 3, 5};

    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tlast_i  = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    src_gap_max    = 5;
    sink_stall_max = 5;

    // Directed field at the reset extent: ignored commands, a ring with a
    // repeated point, closePath with a surplus repeat, moveTo on an empty
    // ring, and a field that ends inside a varint while a ring is open.
    field_bytes.delete();
    add_varint(command(CMD_VOID, '0));
    add_varint(command(CMD_SPARE_LO, 29'd1));
    add_varint(command(CMD_CLOSE, 29'd1));
    add_varint(command(CMD_MOVE, 29'd1));
    add_varint(zz(5));
    add_varint(zz(-3));
    add_varint(command(CMD_LINE, 29'd3));
    add_varint(zz(0));
    add_varint(zz(0));
    add_varint(64'h3FFF);
    add_varint(zz(1));
    add_varint(zz(2));
    add_varint(zz(2));
    add_varint(command(CMD_CLOSE, 29'd2));
    add_varint(command(CMD_MOVE, 29'd1));
    add_varint(zz(1));
    add_varint(zz(1));
    append_byte(8'h80);
    send_field(-1);

    // Over-long varint followed by a field end.
    field_bytes.delete();
    repeat (VARINT_MAX_BYTES) append_byte(8'hFF);
    add_varint(command(CMD_VOID, '0));
    send_field(-1);

    for (int p = 0; p < PHASE_COUNT; p++) begin
      drain(SETTLE_CYCLES);
      program_extent((p == 4) ? 32'($urandom_range(1, 65536)) : extent_plan[p]);
      src_gap_max    = src_plan[p];
      sink_stall_max = sink_plan[p];
      phase_bytes    = 0;
      opening        = 1'b1;
      while (phase_bytes < PHASE_BYTES) begin
        build_field();
        pause_at = -1;
        if (field_bytes.size() > 1 && ((p == 1 && opening) || $urandom_range(0, 9) == 0)) begin
          pause_at = $urandom_range(1, field_bytes.size() - 1);
        end
        send_field(pause_at);
        phase_bytes += field_bytes.size();
        opening      = 1'b0;
      end
    end

    drain(30);
    if (board.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
